FILE: src/wapd_pkg.sv
// Shared types, constants and helpers for the wrapped-angle PD motor command block.
package wapd_pkg;

  // Q16.16 angle constants.
  localparam int unsigned TwoPiQ = 411775;
  localparam int unsigned PiQ    = 205887;

  localparam logic [18:0] TWO_PI = 19'(TwoPiQ);
  localparam logic [18:0] PI     = 19'(PiQ);

  // floor(2^50 / 2pi): quotient estimate is exact or one low for any 32-bit input.
  localparam int unsigned RecipShift = 50;
  localparam logic [31:0] RECIP = 32'((64'd1 << RecipShift) / 64'(TwoPiQ));

  // 2^31 mod 2pi, undoes the offset that makes the angle unsigned.
  localparam logic [18:0] BIAS_MOD = 19'((64'd1 << 31) % 64'(TwoPiQ));

  // Register indexes of the configuration port.
  typedef enum logic [2:0] {
    REG_PGAIN   = 3'd0,
    REG_DGAIN   = 3'd1,
    REG_TBIAS   = 3'd2,
    REG_WSHIFT  = 3'd3,
    REG_T2V     = 3'd4,
    REG_USE_EMF = 3'd5,
    REG_VDRIVE  = 3'd6
  } reg_idx_t;

  // How the back end finishes an item.
  typedef enum logic [1:0] {
    CLS_TORQUE   = 2'd0,
    CLS_VOLT     = 2'd1,
    CLS_VOLT_EMF = 2'd2
  } cls_t;

  typedef struct packed {
    logic signed [31:0] pgain;
    logic signed [31:0] dgain;
    logic signed [31:0] tbias;
    logic signed [18:0] wshift;
    logic signed [31:0] t2v;
    logic               use_emf;
    logic               vdrive;
  } cfg_t;

  // One classified sample as it waits in the queue.
  typedef struct packed {
    logic        [31:0] goal_u;   // goal angle + 2^31, unsigned
    logic        [31:0] meas_u;   // measured angle + 2^31, unsigned
    logic signed [32:0] serr;     // exact speed error
    logic signed [31:0] emf;
    cls_t               cls;
  } item_t;

  // Saturate to the signed 32-bit range.
  function automatic logic [31:0] sat32(input logic signed [63:0] v);
    logic [31:0] res;
    if (v > 64'sd2147483647) begin
      res = 32'h7fff_ffff;
    end else if (v < -64'sd2147483648) begin
      res = 32'h8000_0000;
    end else begin
      res = v[31:0];
    end
    return res;
  endfunction

endpackage

FILE: src/wapd_front.sv
// Front end: decode an input beat into a classified queue item.
module wapd_front
  import wapd_pkg::*;
(
  input  cfg_t               cfg,
  input  logic signed [31:0] measured_angle,
  input  logic signed [31:0] measured_speed,
  input  logic signed [31:0] goal_angle,
  input  logic signed [31:0] goal_speed,
  input  logic signed [31:0] back_emf,
  output item_t              item
);

  always_comb begin
    // Flip the sign bit: adds 2^31 so the modulo works on an unsigned value.
    item.goal_u = {~goal_angle[31], goal_angle[30:0]};
    item.meas_u = {~measured_angle[31], measured_angle[30:0]};
    item.serr   = 33'(goal_speed) - 33'(measured_speed);
    item.emf    = back_emf;
    if (!cfg.vdrive) begin
      item.cls = CLS_TORQUE;
    end else if (cfg.use_emf) begin
      item.cls = CLS_VOLT_EMF;
    end else begin
      item.cls = CLS_VOLT;
    end
  end

endmodule

FILE: src/wapd_queue.sv
// Small FIFO between the front and back ends.
module wapd_queue
  import wapd_pkg::*;
#(
  parameter int DEPTH = 4
) (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push,
  input  item_t push_item,
  output logic  full,
  input  logic  pop,
  output logic  not_empty,
  output item_t head_item
);

  localparam int PtrW = $clog2(DEPTH);
  localparam int CntW = $clog2(DEPTH + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);

  item_t           mem_r [DEPTH];
  logic [PtrW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PtrW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CntW-1:0] count_r, count_nxt;

  assign full      = (count_r == CntW'(DEPTH));
  assign not_empty = (count_r != '0);
  assign head_item = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == LastPtr) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == LastPtr) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

FILE: src/wapd_back.sv
// Back end: eight-stage pipeline from queued item to saturated drive command.
module wapd_back
  import wapd_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  cfg_t               cfg,
  input  logic               head_valid,
  input  item_t              head_item,
  output logic               pop,
  input  logic               out_stall,
  output logic               out_valid,
  output logic signed [31:0] out_drive_command
);

  // Whole pipeline advances together unless the output beat is held.
  logic en;
  logic out_valid_r;

  assign en        = !(out_valid_r && out_stall);
  assign pop       = en && head_valid;
  assign out_valid = out_valid_r;

  // Stage valids: A quotient, B remainder, C angle mod, D error wrap,
  // E products, F torque, G voltage product, then output register.
  logic va_r, vb_r, vc_r, vd_r, ve_r, vf_r, vg_r;

  // Stage A
  logic [63:0]        gprod, mprod;
  logic [13:0]        qg_r, qm_r;
  logic [31:0]        ug_a_r, um_a_r;
  // Stage B
  logic [32:0]        rg_full, rm_full;
  logic [19:0]        rg_b_r, rm_b_r;
  // Stage C
  logic [19:0]        rg_red, rm_red;
  logic signed [19:0] ag_s, am_s;
  logic [18:0]        ag_nxt, am_nxt, ag_c_r, am_c_r;
  // Stage D
  logic signed [20:0] err0, err1, err2, lo_lim, hi_lim, err_d_r;
  // Stage E
  logic signed [52:0] pprod;
  logic signed [64:0] dprod;
  logic signed [36:0] pe_e_r;
  logic signed [48:0] de_e_r;
  // Stage F
  logic signed [49:0] tsum;
  logic signed [31:0] torque_f_r;
  // Stage G
  logic signed [63:0] vprod;
  logic signed [47:0] vt_g_r;
  logic signed [31:0] torque_g_r;
  // Stage H
  logic signed [63:0] cmd_sum;
  logic signed [31:0] cmd_nxt;

  // Items ride along with sideband that later stages need.
  logic signed [32:0] serr_a_r, serr_b_r, serr_c_r, serr_d_r;
  logic signed [31:0] emf_a_r, emf_b_r, emf_c_r, emf_d_r, emf_e_r, emf_f_r, emf_g_r;
  cls_t               cls_a_r, cls_b_r, cls_c_r, cls_d_r, cls_e_r, cls_f_r, cls_g_r;

  always_comb begin
    gprod = 64'(head_item.goal_u) * 64'(RECIP);
    mprod = 64'(head_item.meas_u) * 64'(RECIP);

    rg_full = 33'(ug_a_r) - 33'(qg_r) * 33'(TWO_PI);
    rm_full = 33'(um_a_r) - 33'(qm_r) * 33'(TWO_PI);

    // Remainder is below two periods: one correction, then drop the offset.
    rg_red = (rg_b_r >= 20'(TWO_PI)) ? rg_b_r - 20'(TWO_PI) : rg_b_r;
    rm_red = (rm_b_r >= 20'(TWO_PI)) ? rm_b_r - 20'(TWO_PI) : rm_b_r;
    ag_s   = $signed(rg_red) - $signed(20'(BIAS_MOD));
    am_s   = $signed(rm_red) - $signed(20'(BIAS_MOD));
    ag_nxt = (ag_s < 0) ? 19'(ag_s + $signed(20'(TWO_PI))) : 19'(ag_s);
    am_nxt = (am_s < 0) ? 19'(am_s + $signed(20'(TWO_PI))) : 19'(am_s);

    // Wrap into the shifted window: add a period first, then subtract.
    lo_lim = 21'(cfg.wshift) - $signed(21'(PI));
    hi_lim = 21'(cfg.wshift) + $signed(21'(PI));
    err0   = $signed(21'(ag_c_r)) - $signed(21'(am_c_r));
    err1   = (err0 <= lo_lim) ? err0 + $signed(21'(TWO_PI)) : err0;
    err2   = (err1 > hi_lim) ? err1 - $signed(21'(TWO_PI)) : err1;

    pprod = 53'(cfg.pgain) * 53'(err_d_r);
    dprod = 65'(cfg.dgain) * 65'(serr_d_r);

    tsum = 50'(pe_e_r) + 50'(de_e_r) + 50'(cfg.tbias);

    vprod = 64'(cfg.t2v) * 64'(torque_f_r);

    cmd_sum = 64'(vt_g_r);
    if (cls_g_r == CLS_VOLT_EMF) begin
      cmd_sum = cmd_sum + 64'(emf_g_r);
    end
    case (cls_g_r)
      CLS_TORQUE:   cmd_nxt = torque_g_r;
      CLS_VOLT,
      CLS_VOLT_EMF: cmd_nxt = sat32(cmd_sum);
      default:      cmd_nxt = torque_g_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r        <= 1'b0;
      vb_r        <= 1'b0;
      vc_r        <= 1'b0;
      vd_r        <= 1'b0;
      ve_r        <= 1'b0;
      vf_r        <= 1'b0;
      vg_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      va_r        <= head_valid;
      vb_r        <= va_r;
      vc_r        <= vb_r;
      vd_r        <= vc_r;
      ve_r        <= vd_r;
      vf_r        <= ve_r;
      vg_r        <= vf_r;
      out_valid_r <= vg_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      qg_r     <= gprod[63:RecipShift];
      qm_r     <= mprod[63:RecipShift];
      ug_a_r   <= head_item.goal_u;
      um_a_r   <= head_item.meas_u;
      serr_a_r <= head_item.serr;
      emf_a_r  <= head_item.emf;
      cls_a_r  <= head_item.cls;

      rg_b_r   <= rg_full[19:0];
      rm_b_r   <= rm_full[19:0];
      serr_b_r <= serr_a_r;
      emf_b_r  <= emf_a_r;
      cls_b_r  <= cls_a_r;

      ag_c_r   <= ag_nxt;
      am_c_r   <= am_nxt;
      serr_c_r <= serr_b_r;
      emf_c_r  <= emf_b_r;
      cls_c_r  <= cls_b_r;

      err_d_r  <= err2;
      serr_d_r <= serr_c_r;
      emf_d_r  <= emf_c_r;
      cls_d_r  <= cls_c_r;

      // Dropping 16 low bits of a signed product rounds toward minus infinity.
      pe_e_r   <= pprod[52:16];
      de_e_r   <= dprod[64:16];
      emf_e_r  <= emf_d_r;
      cls_e_r  <= cls_d_r;

      torque_f_r <= sat32(64'(tsum));
      emf_f_r    <= emf_e_r;
      cls_f_r    <= cls_e_r;

      vt_g_r     <= vprod[63:16];
      torque_g_r <= torque_f_r;
      emf_g_r    <= emf_f_r;
      cls_g_r    <= cls_f_r;

      out_drive_command <= cmd_nxt;
    end
  end

endmodule

FILE: src/wrapped_angle_pd_motor_command.sv
// Top level of the wrapped-angle PD motor command block.
//
//  channel | direction | handshake             | payload
//  --------+-----------+-----------------------+------------------------------------------
//  in_     | input     | in_valid / in_stall   | angles, speeds, back-EMF (Q16.16)
//  out_    | output    | out_valid / out_stall | out_drive_command (Q16.16, saturated)
//  cfg_    | input     | cfg_valid / cfg_ready | cfg_index (3 bits), cfg_data (32 bits)
//
//  One sample per cycle sustained while the output is not stalled; an input beat is
//  written into the queue, then passes eight stages: the angle modulo (quotient multiply,
//  remainder, correction), the window wrap, the gain multiplies, torque saturation,
//  the voltage multiply and the output register.
//  Synchronous active-low reset empties the queue and the pipeline and loads register
//  defaults. in_stall rises only when the queue is full; out_stall, while out_valid is high,
//  freezes the whole back pipeline and the front keeps filling the queue.
module wrapped_angle_pd_motor_command
  import wapd_pkg::*;
#(
  parameter int QUEUE_DEPTH = 4   // entries between front and back, at least 2
) (
  input  logic               clk,
  input  logic               rst_n,

  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [31:0] in_measured_angle,
  input  logic signed [31:0] in_measured_speed,
  input  logic signed [31:0] in_goal_angle,
  input  logic signed [31:0] in_goal_speed,
  input  logic signed [31:0] in_back_emf,

  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] out_drive_command,

  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data
);

  cfg_t  cfg_r;
  item_t front_item;
  item_t head_item;
  logic  q_full, q_not_empty, q_pop, q_push;

  // Register writes are always taken; unknown indexes drop the beat.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.pgain   <= '0;
      cfg_r.dgain   <= '0;
      cfg_r.tbias   <= '0;
      cfg_r.wshift  <= '0;
      cfg_r.t2v     <= '0;
      cfg_r.use_emf <= 1'b1;
      cfg_r.vdrive  <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_PGAIN:   cfg_r.pgain   <= cfg_data;
        REG_DGAIN:   cfg_r.dgain   <= cfg_data;
        REG_TBIAS:   cfg_r.tbias   <= cfg_data;
        REG_WSHIFT:  cfg_r.wshift  <= cfg_data[18:0];
        REG_T2V:     cfg_r.t2v     <= cfg_data;
        REG_USE_EMF: cfg_r.use_emf <= cfg_data[0];
        REG_VDRIVE:  cfg_r.vdrive  <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  // Front: classify the beat by drive mode and precompute the speed error.
  wapd_front u_front (
    .cfg            (cfg_r),
    .measured_angle (in_measured_angle),
    .measured_speed (in_measured_speed),
    .goal_angle     (in_goal_angle),
    .goal_speed     (in_goal_speed),
    .back_emf       (in_back_emf),
    .item           (front_item)
  );

  // Stall the input only when the queue has no free entry.
  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;

  wapd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (front_item),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .head_item (head_item)
  );

  // Back: modulo, wrap, PD and voltage scaling, ending in the output register.
  wapd_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg               (cfg_r),
    .head_valid        (q_not_empty),
    .head_item         (head_item),
    .pop               (q_pop),
    .out_stall         (out_stall),
    .out_valid         (out_valid),
    .out_drive_command (out_drive_command)
  );

endmodule
